// ===== design/swcs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sliding window channel statistics block
// depends on nothing; all files but swcs_chan_if and swcs_ram import it
package swcs_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int CHANNELS       = 7;
   localparam int CHAN_IDX_W     = 3;
   localparam int WINDOW_LEN_DEF = 5;
   localparam int MAX_WINDOW_LEN = 16;
   localparam int SLOT_W         = $clog2(MAX_WINDOW_LEN);
   localparam int QUOT_W         = 2 * SAMPLE_W;
   // dividend padded up to whole nibbles for the digit divider
   localparam int DIVIDEND_W     = ((2 * SAMPLE_W + $clog2(MAX_WINDOW_LEN) + 1 + 3) / 4) * 4;
   localparam int ROOT_W         = SAMPLE_W;
   localparam int QUEUE_DEPTH    = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic       req_type;
      sample_type plate_x;
      sample_type plate_y;
      sample_type plate_z;
      sample_type extruder_x;
      sample_type extruder_y;
      sample_type extruder_z;
      sample_type tension_level;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_IDX_W-1:0] channel_index;
      sample_type            window_mean;
      logic [SAMPLE_W-1:0]   window_stddev;
      sample_type            window_max;
      sample_type            window_min;
      logic [SAMPLE_W-1:0]   window_range;
      logic                  last_channel;
   } rsp_item_type;

   // one queued sample: its slot in the window and whether it completes it
   typedef struct packed {
      logic                               fills_window;
      logic [SLOT_W-1:0]                  slot;
      logic [CHANNELS-1:0][SAMPLE_W-1:0]  samples;
   } cmd_type;

   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_ctl_type;

   typedef struct packed {
      logic done;
   } arith_sts_type;

endpackage

// ===== design/swcs_chan_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying one payload per beat
// no dependencies; payload type set where the channel is instantiated
interface swcs_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sliding_window_channel_statistics.sv =====
`timescale 1ns / 1ps
// top level of the sliding window channel statistics block
// depends on swcs_pkg, swcs_chan_if, swcs_front, swcs_cmd_fifo, swcs_back
//
// channel    dir  payload        beat means
// req_chan   in   req_item_type  one sensor sample (seven channels) or a clear
// rsp_chan   out  rsp_item_type  statistics of one channel's window
//
// a clear is taken in the front end and costs no back end time
// a sample that does not complete the window costs the back end one store
// write per channel
// a completing sample is paced by the shared arithmetic unit, which does
// two 18-step divides (one nibble per step) and a 32-step root per
// channel
// synchronous active-high reset clears the fill count, queue and sequencer;
// the sample store needs no clearing
// a two-deep queue lets the front accept while the back end works, and the
// output register holds a beat while rsp_chan is stalled
module sliding_window_channel_statistics #(
   parameter int WINDOW_LEN = swcs_pkg::WINDOW_LEN_DEF
) (
   input logic         clock,
   input logic         reset,
   swcs_chan_if.sink   req_chan,
   swcs_chan_if.source rsp_chan
);
   import swcs_pkg::*;

   // front end side of the queue and back end side
   swcs_chan_if #(.payload_type(cmd_type)) cmd_push_chan ();
   swcs_chan_if #(.payload_type(cmd_type)) cmd_pop_chan ();

   // classifies beats and keeps the window fill count
   swcs_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_chan (cmd_push_chan)
   );

   swcs_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_chan (cmd_push_chan),
      .pop_chan  (cmd_pop_chan)
   );

   // stores samples and walks the channels when a window completes
   swcs_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_chan (cmd_pop_chan),
      .rsp_chan (rsp_chan)
   );
endmodule

// ===== design/swcs_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module swcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 35
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/swcs_front.sv =====
`timescale 1ns / 1ps
// front end: takes request beats, handles clears, tracks window fill
// depends on swcs_pkg and swcs_chan_if
module swcs_front #(
   parameter int WINDOW_LEN = swcs_pkg::WINDOW_LEN_DEF
) (
   input logic         clock,
   input logic         reset,
   swcs_chan_if.sink   req_chan,
   swcs_chan_if.source cmd_chan
);
   import swcs_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_LEN);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              is_clear;
   logic              accept;
   logic              fills;

   assign is_clear = req_chan.payload.req_type;
   assign accept   = req_chan.valid && req_chan.ready;
   assign fills    = (fill_ff == FILL_W'(WINDOW_LEN - 1));

   assign req_chan.ready = cmd_chan.ready;
   assign cmd_chan.valid = req_chan.valid && !is_clear;

   always_comb begin
      cmd_chan.payload.fills_window = fills;
      cmd_chan.payload.slot         = SLOT_W'(fill_ff);
      cmd_chan.payload.samples[0]   = req_chan.payload.plate_x;
      cmd_chan.payload.samples[1]   = req_chan.payload.plate_y;
      cmd_chan.payload.samples[2]   = req_chan.payload.plate_z;
      cmd_chan.payload.samples[3]   = req_chan.payload.extruder_x;
      cmd_chan.payload.samples[4]   = req_chan.payload.extruder_y;
      cmd_chan.payload.samples[5]   = req_chan.payload.extruder_z;
      cmd_chan.payload.samples[6]   = req_chan.payload.tension_level;
   end

   // a full window restarts at one: the newest sample carries over
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (is_clear) begin
            fill_in = '0;
         end else if (fills) begin
            fill_in = FILL_W'(1);
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end
endmodule

// ===== design/swcs_cmd_fifo.sv =====
`timescale 1ns / 1ps
// short queue of sample commands between front and back end
// depends on swcs_pkg and swcs_chan_if
module swcs_cmd_fifo (
   input logic         clock,
   input logic         reset,
   swcs_chan_if.sink   push_chan,
   swcs_chan_if.source pop_chan
);
   import swcs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_chan.ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_chan.valid   = (count_ff != '0);
   assign pop_chan.payload = entry_ff[rd_ptr_ff];
   assign push = push_chan.valid && push_chan.ready;
   assign pop  = pop_chan.valid && pop_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ===== design/swcs_arith.sv =====
`timescale 1ns / 1ps
// shared multi-cycle unit: divide by the window length one nibble per cycle,
// or integer square root; depends on swcs_pkg
module swcs_arith #(
   parameter int WINDOW_LEN = swcs_pkg::WINDOW_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  swcs_pkg::arith_ctl_type         ctl,
   input  logic [swcs_pkg::DIVIDEND_W-1:0] operand,
   output swcs_pkg::arith_sts_type         sts,
   output logic [swcs_pkg::QUOT_W-1:0]     result
);
   import swcs_pkg::*;

   localparam int REM_W       = $clog2(WINDOW_LEN) + 1;
   localparam int CNT_W       = $clog2(DIVIDEND_W);
   localparam int SQ_REM_W    = ROOT_W + 3;
   localparam int DIG_W       = 4;
   localparam int DIV_STEPS   = DIVIDEND_W / DIG_W;
   localparam int CUR_W       = REM_W + DIG_W;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;
   localparam int RECIP       = (2 ** RECIP_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int PROD_W      = CUR_W + RECIP_W;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   arith_op_type          op_ff, op_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] work_ff, work_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [SQ_REM_W-1:0]   sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   logic [CUR_W-1:0]      div_cur, div_back, div_left;
   logic [PROD_W-1:0]     div_prod;
   logic [DIG_W-1:0]      div_q;
   logic [SQ_REM_W-1:0]   sq_t, sq_trial;
   logic                  sq_ge;

   // long division by a constant, one nibble per cycle; the quotient digit
   // comes from a reciprocal multiply, exact since the partial value is small
   assign div_cur  = {rem_ff, work_ff[DIVIDEND_W-1 -: DIG_W]};
   assign div_prod = PROD_W'(div_cur) * PROD_W'(RECIP);
   assign div_q    = div_prod[RECIP_SHIFT +: DIG_W];
   assign div_back = CUR_W'(div_q) * CUR_W'(WINDOW_LEN);
   assign div_left = div_cur - div_back;

   // digit by digit root: two radicand bits, one root bit per cycle
   assign sq_t     = {sq_rem_ff[SQ_REM_W-3:0], work_ff[QUOT_W-1 -: 2]};
   assign sq_trial = SQ_REM_W'({root_ff, 2'b01});
   assign sq_ge    = (sq_t >= sq_trial);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      sq_rem_in = sq_rem_ff;
      root_in   = root_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         op_in     = ctl.op;
         work_in   = operand;
         rem_in    = '0;
         sq_rem_in = '0;
         root_in   = '0;
         cnt_in    = (ctl.op == OP_SQRT) ? CNT_W'(ROOT_W - 1) : CNT_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         if (op_ff == OP_SQRT) begin
            sq_rem_in = sq_ge ? sq_t - sq_trial : sq_t;
            root_in   = {root_ff[ROOT_W-2:0], sq_ge};
            work_in   = {work_ff[DIVIDEND_W-3:0], 2'b00};
         end else begin
            rem_in  = div_left[REM_W-1:0];
            work_in = {work_ff[DIVIDEND_W-DIG_W-1:0], div_q};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      work_ff   <= work_in;
      rem_ff    <= rem_in;
      sq_rem_ff <= sq_rem_in;
      root_ff   <= root_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done = done_ff;
   assign result   = (op_ff == OP_SQRT) ? QUOT_W'(root_ff) : work_ff[QUOT_W-1:0];
endmodule

// ===== design/swcs_back.sv =====
`timescale 1ns / 1ps
// back end: stores samples, computes per channel window statistics
// depends on swcs_pkg, swcs_chan_if, swcs_ram and swcs_arith
module swcs_back #(
   parameter int WINDOW_LEN = swcs_pkg::WINDOW_LEN_DEF
) (
   input logic         clock,
   input logic         reset,
   swcs_chan_if.sink   cmd_chan,
   swcs_chan_if.source rsp_chan
);
   import swcs_pkg::*;

   localparam int DEPTH  = CHANNELS * WINDOW_LEN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(WINDOW_LEN);
   localparam int CH_W   = $clog2(CHANNELS);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN) + 1;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_WRITE     = 10'b00_0000_0010,
      ST_SCAN      = 10'b00_0000_0100,
      ST_SCAN_TAIL = 10'b00_0000_1000,
      ST_MEAN      = 10'b00_0001_0000,
      ST_DEV       = 10'b00_0010_0000,
      ST_DEV_TAIL  = 10'b00_0100_0000,
      ST_VAR       = 10'b00_1000_0000,
      ST_ROOT      = 10'b01_0000_0000,
      ST_OUT       = 10'b10_0000_0000
   } state_type;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [ADDR_W-1:0]        base_ff, base_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     rdv_ff, rdv_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   sample_type               max_ff, max_in;
   sample_type               min_ff, min_in;
   sample_type               mean_ff, mean_in;
   logic [DIVIDEND_W-1:0]    sumsq_ff, sumsq_in;
   logic                     pa_valid_ff, pa_valid_in;
   logic                     pa_cmd_ff, pa_cmd_in;
   logic                     pb_valid_ff, pb_valid_in;
   logic [DIFF_W-1:0]        pb_abs_ff, pb_abs_in;
   logic                     pc_valid_ff, pc_valid_in;
   logic [SQ_W-1:0]          pc_sq_ff, pc_sq_in;
   logic                     go_ff, go_in;
   logic [ROOT_W-1:0]        sd_ff, sd_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_item_type             out_ff, out_in;

   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
   logic [SAMPLE_W-1:0]      ram_wdata, ram_rdata;

   arith_ctl_type            arith_ctl;
   arith_sts_type            arith_sts;
   logic [DIVIDEND_W-1:0]    arith_operand;
   logic [QUOT_W-1:0]        arith_result;

   sample_type               cur_sample, rd_sample, elem;
   logic signed [DIFF_W-1:0] diff;
   logic [SUM_W-1:0]         abs_sum;
   logic [SAMPLE_W-1:0]      quot32;
   logic                     last_ch, out_free;

   swcs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   swcs_arith #(.WINDOW_LEN(WINDOW_LEN)) u_arith (
      .clock   (clock),
      .reset   (reset),
      .ctl     (arith_ctl),
      .operand (arith_operand),
      .sts     (arith_sts),
      .result  (arith_result)
   );

   assign cur_sample = $signed(cmd_ff.samples[ch_ff]);
   assign rd_sample  = $signed(ram_rdata);
   assign elem       = pa_cmd_ff ? cur_sample : rd_sample;
   assign diff       = DIFF_W'(elem) - DIFF_W'(mean_ff);
   assign abs_sum    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign quot32     = arith_result[SAMPLE_W-1:0];
   assign last_ch    = (ch_ff == CH_W'(CHANNELS - 1));
   assign out_free   = !out_valid_ff || rsp_chan.ready;

   assign cmd_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   assign arith_ctl.start = go_ff;
   assign arith_ctl.op    = (state_ff == ST_ROOT) ? OP_SQRT : OP_DIV;

   always_comb begin
      case (state_ff)
         ST_VAR:  arith_operand = sumsq_ff;
         ST_ROOT: arith_operand = DIVIDEND_W'(arith_result);
         default: arith_operand = DIVIDEND_W'(abs_sum);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      rdv_in       = 1'b0;
      sum_in       = sum_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      mean_in      = mean_ff;
      sumsq_in     = sumsq_ff;
      pa_valid_in  = 1'b0;
      pa_cmd_in    = pa_cmd_ff;
      go_in        = 1'b0;
      sd_in        = sd_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      ram_we       = 1'b0;
      ram_waddr    = base_ff;
      ram_wdata    = cur_sample;
      ram_raddr    = base_ff + ADDR_W'(idx_ff);

      // first pass: sum, max and min of the stored entries
      if (rdv_ff) begin
         sum_in = sum_ff + SUM_W'(rd_sample);
         if (rd_sample > max_ff) begin
            max_in = rd_sample;
         end
         if (rd_sample < min_ff) begin
            min_in = rd_sample;
         end
      end

      // second pass: deviation, square, accumulate
      pb_valid_in = pa_valid_ff;
      pb_abs_in   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      pc_valid_in = pb_valid_ff;
      pc_sq_in    = pb_abs_ff * pb_abs_ff;
      if (pc_valid_ff) begin
         sumsq_in = sumsq_ff + DIVIDEND_W'(pc_sq_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_chan.valid) begin
               cmd_in   = cmd_chan.payload;
               state_in = cmd_chan.payload.fills_window ? ST_SCAN : ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = base_ff + ADDR_W'(cmd_ff.slot);
            if (last_ch) begin
               ch_in    = '0;
               base_in  = '0;
               state_in = ST_IDLE;
            end else begin
               ch_in   = ch_ff + CH_W'(1);
               base_in = base_ff + ADDR_W'(WINDOW_LEN);
            end
         end
         ST_SCAN: begin
            rdv_in = 1'b1;
            // the completing sample is not read from the store; it seeds the pass
            if (idx_ff == '0) begin
               sum_in = SUM_W'(cur_sample);
               max_in = cur_sample;
               min_in = cur_sample;
            end
            if (idx_ff == IDX_W'(WINDOW_LEN - 2)) begin
               idx_in   = '0;
               state_in = ST_SCAN_TAIL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SCAN_TAIL: begin
            go_in    = 1'b1;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            if (arith_sts.done) begin
               mean_in  = sum_ff[SUM_W-1] ? SAMPLE_W'(-quot32) : quot32;
               state_in = ST_DEV;
            end
         end
         ST_DEV: begin
            pa_valid_in = 1'b1;
            if (idx_ff == '0) begin
               sumsq_in = '0;
            end
            if (idx_ff == IDX_W'(WINDOW_LEN - 1)) begin
               // carry the newest sample over as slot zero of the next window
               pa_cmd_in = 1'b1;
               ram_we    = 1'b1;
               idx_in    = '0;
               state_in  = ST_DEV_TAIL;
            end else begin
               pa_cmd_in = 1'b0;
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         ST_DEV_TAIL: begin
            if (!pa_valid_ff && !pb_valid_ff && !pc_valid_ff) begin
               go_in    = 1'b1;
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            if (arith_sts.done) begin
               go_in    = 1'b1;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (arith_sts.done) begin
               sd_in    = arith_result[ROOT_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               out_in.channel_index = CHAN_IDX_W'(ch_ff);
               out_in.window_mean   = mean_ff;
               out_in.window_stddev = sd_ff;
               out_in.window_max    = max_ff;
               out_in.window_min    = min_ff;
               out_in.window_range  = max_ff - min_ff;
               out_in.last_channel  = last_ch;
               if (last_ch) begin
                  ch_in    = '0;
                  base_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  base_in  = base_ff + ADDR_W'(WINDOW_LEN);
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      sum_ff    <= sum_in;
      max_ff    <= max_in;
      min_ff    <= min_in;
      mean_ff   <= mean_in;
      sumsq_ff  <= sumsq_in;
      pa_cmd_ff <= pa_cmd_in;
      pb_abs_ff <= pb_abs_in;
      pc_sq_ff  <= pc_sq_in;
      sd_ff     <= sd_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         base_ff      <= '0;
         idx_ff       <= '0;
         rdv_ff       <= 1'b0;
         pa_valid_ff  <= 1'b0;
         pb_valid_ff  <= 1'b0;
         pc_valid_ff  <= 1'b0;
         go_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         base_ff      <= base_in;
         idx_ff       <= idx_in;
         rdv_ff       <= rdv_in;
         pa_valid_ff  <= pa_valid_in;
         pb_valid_ff  <= pb_valid_in;
         pc_valid_ff  <= pc_valid_in;
         go_ff        <= go_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

// ===== tb/swcs_scoreboard.sv =====
`timescale 1ns / 1ps
// window statistics predictor and expected-beat store for the testbench
// depends on swcs_pkg
package swcs_scoreboard_pkg;
   import swcs_pkg::*;

   localparam int WLEN = WINDOW_LEN_DEF;

   class swcs_scoreboard;
      longint            win [CHANNELS][WLEN];
      int unsigned       fill;
      rsp_item_type      stats_due [$];
      int                errors;

      function new();
         fill = 0;
         errors = 0;
      endfunction

      // integer root of a 64-bit value, bit by bit
      function automatic logic [31:0] root64(logic [63:0] v);
         logic [63:0] r;
         logic [63:0] c;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
         end
         return r[31:0];
      endfunction

      // note one accepted request beat, queue any statistics it causes
      function void note_request(req_item_type it);
         sample_type   vals [CHANNELS];
         longint       sum, mx, mn, mean, d;
         logic [127:0] sq_sum;
         logic [127:0] var_q;
         rsp_item_type r;
         if (it.req_type) begin
            fill = 0;
            return;
         end
         vals = '{it.plate_x, it.plate_y, it.plate_z, it.extruder_x,
                  it.extruder_y, it.extruder_z, it.tension_level};
         if (fill >= WLEN) fill = 0;
         for (int c = 0; c < CHANNELS; c++) win[c][fill] = longint'(vals[c]);
         fill++;
         if (fill < WLEN) return;
         for (int c = 0; c < CHANNELS; c++) begin
            sum = 0;
            mx = win[c][0];
            mn = win[c][0];
            for (int i = 0; i < WLEN; i++) begin
               sum += win[c][i];
               if (win[c][i] > mx) mx = win[c][i];
               if (win[c][i] < mn) mn = win[c][i];
            end
            mean = sum / WLEN;
            sq_sum = 0;
            for (int i = 0; i < WLEN; i++) begin
               d = win[c][i] - mean;
               if (d < 0) d = -d;
               sq_sum += 128'(d) * 128'(d);
            end
            var_q = sq_sum / WLEN;
            r.channel_index = c[CHAN_IDX_W-1:0];
            r.window_mean   = mean[31:0];
            r.window_stddev = root64(var_q[63:0]);
            r.window_max    = mx[31:0];
            r.window_min    = mn[31:0];
            r.window_range  = 32'(mx - mn);
            r.last_channel  = (c == CHANNELS - 1);
            stats_due.push_back(r);
         end
         for (int c = 0; c < CHANNELS; c++) win[c][0] = win[c][WLEN-1];
         fill = 1;
      endfunction

      task report(string what, longint got, longint want);
         $display("error: %s got %0h expected %0h", what, got, want);
         errors++;
      endtask

      // compare one accepted response beat with the oldest expectation
      task check_stats(rsp_item_type got);
         rsp_item_type want;
         if (stats_due.size() == 0) begin
            report("unexpected beat, channel", got.channel_index, 0);
            return;
         end
         want = stats_due.pop_front();
         if (got.channel_index !== want.channel_index)
            report("channel_index", got.channel_index, want.channel_index);
         if (got.window_mean !== want.window_mean)
            report("window_mean", got.window_mean, want.window_mean);
         if (got.window_stddev !== want.window_stddev)
            report("window_stddev", got.window_stddev, want.window_stddev);
         if (got.window_max !== want.window_max)
            report("window_max", got.window_max, want.window_max);
         if (got.window_min !== want.window_min)
            report("window_min", got.window_min, want.window_min);
         if (got.window_range !== want.window_range)
            report("window_range", got.window_range, want.window_range);
         if (got.last_channel !== want.last_channel)
            report("last_channel", got.last_channel, want.last_channel);
      endtask
   endclass
endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// top of the sliding window channel statistics testbench
// depends on swcs_pkg, swcs_chan_if, the block and swcs_scoreboard_pkg
module tb_top;
   import swcs_pkg::*;
   import swcs_scoreboard_pkg::*;

   logic clock = 0;
   logic reset = 1;

   swcs_chan_if #(.payload_type(req_item_type)) req_chan ();
   swcs_chan_if #(.payload_type(rsp_item_type)) rsp_chan ();

   sliding_window_channel_statistics uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   swcs_scoreboard sb = new();

   // idle percentages for sender and receiver, set per phase
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_off = 0;      // cycles the receiver still holds off
   bit  stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.payload = '0;
      rsp_chan.ready = 0;
   end

   // accepted beats feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_stats(rsp_chan.payload);
      end
   end

   // receiver: random stalls, plus the long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic sample_type pick_value();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return sample_type'($urandom_range(255)) - 128;
         3: return sample_type'($urandom_range(32'h3_0000)) - 32'sh1_8000;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic req_item_type make_sample(sample_type v);
      req_item_type it;
      it.req_type = 0;
      it.plate_x = v; it.plate_y = v; it.plate_z = v; it.extruder_x = v;
      it.extruder_y = v; it.extruder_z = v; it.tension_level = v;
      return it;
   endfunction

   function automatic req_item_type rand_sample();
      req_item_type it;
      it.req_type = 0;
      it.plate_x = pick_value(); it.plate_y = pick_value();
      it.plate_z = pick_value(); it.extruder_x = pick_value();
      it.extruder_y = pick_value(); it.extruder_z = pick_value();
      it.tension_level = pick_value();
      return it;
   endfunction

   // offer one beat after a random gap, wait for acceptance; valid stays up
   // into the next beat unless a gap follows
   task send_beat(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task send_clear();
      req_item_type it;
      it = rand_sample();
      it.req_type = 1;
      send_beat(it);
   endtask

   task random_phase(int n, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < n; i++) begin
         // mostly samples; occasional clear breaks a window
         if ($urandom_range(99) < 8) send_clear();
         else send_beat(rand_sample());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, clear mid-window, a flat window
      send_beat(make_sample(32'sh7fff_ffff));
      send_beat(make_sample(32'sh8000_0000));
      send_beat(make_sample(32'sh7fff_ffff));
      send_beat(make_sample(32'sh8000_0000));
      send_beat(make_sample(32'sh7fff_ffff));
      send_beat(make_sample(32'sh8000_0000));
      send_beat(make_sample(32'sh8000_0000));
      send_clear();
      send_beat(make_sample(32'sh0001_0000));
      send_beat(make_sample(32'sh0001_0000));
      send_clear();
      for (int i = 0; i < 5; i++) send_beat(make_sample(-32'sh0000_0003));
      for (int i = 0; i < 4; i++) send_beat(rand_sample());
      send_clear();
      send_clear();

      // random phases with different idle mixes
      random_phase(19, 0, 0);
      random_phase(19, 55, 0);
      random_phase(19, 0, 55);
      // long receiver hold-off while the sender keeps offering beats
      hold_off <= 8000;
      random_phase(12, 0, 0);
      random_phase(19, 13, 13);
      req_chan.valid <= 0;
      stim_done = 1;
   end

   // end of run: drain, then a short tail
   initial begin
      wait (stim_done);
      while (sb.stats_due.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (sb.errors == 0 && sb.stats_due.size() == 0)
         $display("sliding_window_channel_statistics: match");
      else
         $display("sliding_window_channel_statistics: mismatch");
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #60ms;
      $display("sliding_window_channel_statistics: mismatch");
      $finish;
   end
endmodule

// ===== sim.f =====
design/swcs_pkg.sv
design/swcs_chan_if.sv
design/swcs_ram.sv
design/swcs_front.sv
design/swcs_cmd_fifo.sv
design/swcs_arith.sv
design/swcs_back.sv
design/sliding_window_channel_statistics.sv
tb/swcs_scoreboard.sv
tb/tb_top.sv
